### sv/lad_pkg.sv
// Shared types and constants for the linear array deque.
// Holds operation codes, status codes and the per-transaction result record.
// No dependencies.
package lad_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PUSH_REFUSE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_POP_REFUSE  = 2'd2;

    // value returned when nothing was popped
    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    // outcome of one operation, handed from control to the output stage
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              is_empty;
        logic              is_full;
        logic              pop_ok;
    } lad_res_t;

endpackage

### sv/linear_array_deque.sv
// Top level of the linear array deque: stream ports, output register.
// Instantiates lad_ctrl and lad_ram; depends on lad_pkg.
//
// Double-ended queue in a non-wrapping array of DEPTH 32-bit slots. Each input
// transaction (tuser = operation, tdata = value) gives exactly one output
// transaction with the popped value (or -1), a status code and empty/full
// flags. On acceptance, positions move and the slot memory is written or
// read, and the result waits for the registered slot read data. A new item
// is taken once the previous result has entered the output register and
// that register is free or being drained. Capacity (cfg_we/cfg_wdata) is
// clamped to 1..DEPTH; the user must write it only while idle; not enforced.
module linear_array_deque #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,      // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [31:0] push_value
    input  logic [1:0]  s_tuser,        // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata         // [31:0] pop_value, [33:32] status,
                                        // [34] is_empty, [35] is_full, rest zero
);
    import lad_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);

    logic              accept;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    lad_res_t          res, pend_reg;
    logic              busy_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] pop_value;

    // handshake: one item in flight, output register must be free next cycle
    assign s_tready = !busy_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    lad_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .PTR_W  (PTR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .mode       (s_tuser),
        .push_value (s_tdata),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .res        (res)
    );

    lad_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // hold the outcome while the slot read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= res;
        end
    end

    assign pop_value = pend_reg.pop_ok ? mem_rdata : NO_VALUE;

    // busy flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            m_tdata <= {4'b0000, pend_reg.is_full, pend_reg.is_empty,
                        pend_reg.status, pop_value};
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### sv/lad_ram.sv
// Slot storage for the linear array deque: one write port, one read port.
// Read data is registered. Depends on lad_pkg.
module lad_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [lad_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [lad_pkg::DATA_W-1:0] rdata
);
    import lad_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/lad_ctrl.sv
// Position and capacity control for the linear array deque.
// Decides each operation, moves front and rear, drives the slot memory ports.
// Depends on lad_pkg.
module lad_ctrl #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int PTR_W  = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lad_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        accept,
    input  logic [lad_pkg::MODE_W-1:0]  mode,
    input  logic [lad_pkg::DATA_W-1:0]  push_value,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [lad_pkg::DATA_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    output lad_pkg::lad_res_t           res
);
    import lad_pkg::*;

    localparam int CMP_W = (PTR_W > CAP_W) ? PTR_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

    logic [CAP_W-1:0] cap_reg;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] rear_reg, rear_next;
    logic [CMP_W-1:0] cap_ext, cap_eff;
    logic             nonempty;

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            cap_eff = ONE_C;
        end
        else if (cap_ext > DEPTH_C)
        begin
            cap_eff = DEPTH_C;
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign nonempty = (front_reg < rear_reg);

    // operation decode, memory access and next positions
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = ADDR_W'(rear_reg);
        mem_raddr  = ADDR_W'(front_reg);
        mem_wdata  = push_value;
        res.status = STAT_DONE;
        res.pop_ok = 1'b0;
        case (mode)
            MODE_PUSH_REAR:
            begin
                if (CMP_W'(rear_reg) >= cap_eff)
                begin
                    res.status = STAT_PUSH_REFUSE;
                end
                else
                begin
                    mem_we    = accept;
                    mem_waddr = ADDR_W'(rear_reg);
                    rear_next = rear_reg + PTR_W'(1);
                end
            end
            MODE_PUSH_FRONT:
            begin
                if (front_reg == '0)
                begin
                    res.status = STAT_PUSH_REFUSE;
                end
                else
                begin
                    mem_we     = accept;
                    mem_waddr  = ADDR_W'(front_reg - PTR_W'(1));
                    front_next = front_reg - PTR_W'(1);
                end
            end
            MODE_POP_FRONT:
            begin
                if (!nonempty)
                begin
                    res.status = STAT_POP_REFUSE;
                end
                else
                begin
                    mem_re     = accept;
                    mem_raddr  = ADDR_W'(front_reg);
                    front_next = front_reg + PTR_W'(1);
                    res.pop_ok = 1'b1;
                end
            end
            default:
            begin
                if (!nonempty)
                begin
                    res.status = STAT_POP_REFUSE;
                end
                else
                begin
                    mem_re     = accept;
                    mem_raddr  = ADDR_W'(rear_reg - PTR_W'(1));
                    rear_next  = rear_reg - PTR_W'(1);
                    res.pop_ok = 1'b1;
                end
            end
        endcase
        res.is_empty = (front_next == rear_next);
        res.is_full  = (CMP_W'(rear_next) >= cap_eff);
    end

    // position and capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
            end
        end
    end

endmodule
